// File: design/lapd_pkg.sv
// shared constants, types and register codes for the light average to pwm duty block
`timescale 1ns / 1ps

package lapd_pkg;

  // window depth of the sample ring
  localparam int WINDOW   = 10;

  localparam int SAMPLE_W = 12;
  localparam int TOP_W    = 16;
  localparam int THR_W    = 12;
  localparam int CNT_W    = $clog2(WINDOW + 1);
  localparam int IDX_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W    = SAMPLE_W + CNT_W;

  // duty fractions are tenths of the top value
  localparam int TENTHS   = 10;
  localparam int K_W      = 4;
  localparam int PROD_W   = TOP_W + K_W;

  // reciprocal of ten, floor is exact for every scaled top value below 2^20
  localparam int RECIP_SHIFT = 23;
  localparam logic [PROD_W-1:0] RECIP_TENTH =
    PROD_W'(((1 << RECIP_SHIFT) + TENTHS - 1) / TENTHS);

  // divider sizing for the mean
  localparam int DIV_W    = SUM_W;
  localparam int DVSR_W   = CNT_W;
  localparam int DCNT_W   = $clog2(DIV_W + 1);

  // configuration register codes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_DUTY_TOP   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_THR_FULL   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_THR_EIGHTY = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_THR_HALF   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_THR_THIRTY = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_THR_TENTH  = 3'd5;

  // register reset values
  localparam logic [TOP_W-1:0] RST_DUTY_TOP   = 16'd12500;
  localparam logic [THR_W-1:0] RST_THR_FULL   = 12'd500;
  localparam logic [THR_W-1:0] RST_THR_EIGHTY = 12'd600;
  localparam logic [THR_W-1:0] RST_THR_HALF   = 12'd800;
  localparam logic [THR_W-1:0] RST_THR_THIRTY = 12'd1100;
  localparam logic [THR_W-1:0] RST_THR_TENTH  = 12'd1600;

  // duty step multipliers in tenths
  localparam logic [K_W-1:0] K_EIGHTY = 4'd8;
  localparam logic [K_W-1:0] K_HALF   = 4'd5;
  localparam logic [K_W-1:0] K_THIRTY = 4'd3;
  localparam logic [K_W-1:0] K_TENTH  = 4'd1;

  typedef struct packed {
    logic [TOP_W-1:0] duty_top;
    logic [THR_W-1:0] thr_full;
    logic [THR_W-1:0] thr_eighty;
    logic [THR_W-1:0] thr_half;
    logic [THR_W-1:0] thr_thirty;
    logic [THR_W-1:0] thr_tenth;
  } cfg_regs_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: design/lapd_cfg.sv
// configuration register file
`timescale 1ns / 1ps

module lapd_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [lapd_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [lapd_pkg::TOP_W-1:0]     wr_data,
  output lapd_pkg::cfg_regs_t            regs
);

  lapd_pkg::cfg_regs_t regs_r;
  lapd_pkg::cfg_regs_t regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      unique case (wr_index)
        lapd_pkg::REG_DUTY_TOP:   regs_nxt.duty_top   = wr_data;
        lapd_pkg::REG_THR_FULL:   regs_nxt.thr_full   = wr_data[lapd_pkg::THR_W-1:0];
        lapd_pkg::REG_THR_EIGHTY: regs_nxt.thr_eighty = wr_data[lapd_pkg::THR_W-1:0];
        lapd_pkg::REG_THR_HALF:   regs_nxt.thr_half   = wr_data[lapd_pkg::THR_W-1:0];
        lapd_pkg::REG_THR_THIRTY: regs_nxt.thr_thirty = wr_data[lapd_pkg::THR_W-1:0];
        lapd_pkg::REG_THR_TENTH:  regs_nxt.thr_tenth  = wr_data[lapd_pkg::THR_W-1:0];
        default:                  regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.duty_top   <= lapd_pkg::RST_DUTY_TOP;
      regs_r.thr_full   <= lapd_pkg::RST_THR_FULL;
      regs_r.thr_eighty <= lapd_pkg::RST_THR_EIGHTY;
      regs_r.thr_half   <= lapd_pkg::RST_THR_HALF;
      regs_r.thr_thirty <= lapd_pkg::RST_THR_THIRTY;
      regs_r.thr_tenth  <= lapd_pkg::RST_THR_TENTH;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

// File: design/lapd_div.sv
// restoring divider for the mean, one quotient bit per cycle
`timescale 1ns / 1ps

module lapd_div (
  input  logic                clk,
  input  logic                rst_n,
  input  lapd_pkg::div_req_t  req,
  output lapd_pkg::div_rsp_t  rsp
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [lapd_pkg::DCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [lapd_pkg::DIV_W-1:0]    quo_r, quo_nxt;
  logic [lapd_pkg::DVSR_W-1:0]   rem_r, rem_nxt;
  logic [lapd_pkg::DVSR_W-1:0]   dvsr_r, dvsr_nxt;
  logic [lapd_pkg::DVSR_W:0]     trial;
  logic                          fits;

  // partial remainder shifted left with the next dividend bit
  assign trial = {rem_r, quo_r[lapd_pkg::DIV_W-1]};
  assign fits  = (trial >= {1'b0, dvsr_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvsr_nxt = dvsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = lapd_pkg::DCNT_W'(lapd_pkg::DIV_W);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvsr_nxt = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? lapd_pkg::DVSR_W'(trial - {1'b0, dvsr_r})
                     : lapd_pkg::DVSR_W'(trial);
      quo_nxt = {quo_r[lapd_pkg::DIV_W-2:0], fits};
      cnt_nxt = cnt_r - lapd_pkg::DCNT_W'(1);
      if (cnt_r == lapd_pkg::DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dvsr_r <= dvsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// File: design/light_average_to_pwm_duty_top.sv
// top level: sample ring, summing sequencer, duty step map and mean divider
`timescale 1ns / 1ps

//  channel | ports                                      | direction
//  --------+--------------------------------------------+----------
//  in      | in_valid, in_ready, in_light_sample        | sink
//  out     | out_valid, out_ready, out_mean_level,      | source
//          | out_duty_value                             |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data  | sink
//
//  one transaction runs from acceptance through ST_SUM, ST_DIV_MEAN and ST_MAP to
//  ST_OUT, by way of ST_DIV_DUTY when the duty is a fractional step (eight, five,
//  three or one tenth); the mean runs on the 16-step restoring divider; the divide
//  by ten is a reciprocal multiply in a state of its own
//  synchronous active-low reset clears write slot, fill count, sequencer, out_valid and
//  the configuration registers to their defaults; ring contents are not cleared
//  a result held back by out_ready keeps the sequencer in its output state, and
//  in_ready stays low until the block is back in idle

module light_average_to_pwm_duty_top (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [lapd_pkg::SAMPLE_W-1:0]     in_light_sample,

  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lapd_pkg::SAMPLE_W-1:0]     out_mean_level,
  output logic [lapd_pkg::TOP_W-1:0]        out_duty_value,

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lapd_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [lapd_pkg::TOP_W-1:0]        cfg_data
);

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_SUM      = 6'b000010,
    ST_DIV_MEAN = 6'b000100,
    ST_MAP      = 6'b001000,
    ST_DIV_DUTY = 6'b010000,
    ST_OUT      = 6'b100000
  } state_t;

  state_t                          state_r, state_nxt;

  // sample ring, no reset: only entries already written are ever summed
  logic [lapd_pkg::SAMPLE_W-1:0]   ring_r [lapd_pkg::WINDOW];
  logic [lapd_pkg::IDX_W-1:0]      write_slot_r, write_slot_nxt;
  logic [lapd_pkg::CNT_W-1:0]      fill_count_r, fill_count_nxt;

  // summing walk over the filled entries
  logic [lapd_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  logic [lapd_pkg::SUM_W-1:0]      sum_r, sum_nxt, sum_acc;
  logic                            last_entry;

  // working results
  logic [lapd_pkg::SAMPLE_W-1:0]   mean_r, mean_nxt;
  logic [lapd_pkg::TOP_W-1:0]      duty_r, duty_nxt;
  logic [lapd_pkg::PROD_W-1:0]     scaled_r, scaled_nxt;

  // output register
  logic                            out_valid_r, out_valid_nxt;
  logic [lapd_pkg::SAMPLE_W-1:0]   out_mean_r, out_mean_nxt;
  logic [lapd_pkg::TOP_W-1:0]      out_duty_r, out_duty_nxt;

  // duty step decode
  logic                            step_full, step_zero;
  logic [lapd_pkg::K_W-1:0]        step_k;
  logic [lapd_pkg::PROD_W-1:0]     top_scaled;
  logic [2*lapd_pkg::PROD_W-1:0]   duty_prod;

  lapd_pkg::cfg_regs_t             regs;
  lapd_pkg::div_req_t              div_req;
  lapd_pkg::div_rsp_t              div_rsp;

  logic                            in_take;
  logic                            out_load;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  lapd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (regs)
  );

  lapd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_take  = in_valid && in_ready;

  // running sum with the entry at the walk pointer
  assign sum_acc    = sum_r + lapd_pkg::SUM_W'(ring_r[idx_r]);
  assign last_entry = ((lapd_pkg::CNT_W'(idx_r) + lapd_pkg::CNT_W'(1)) == fill_count_r);

  // thresholds checked in fixed order, first hit wins
  always_comb begin
    step_full = 1'b0;
    step_zero = 1'b0;
    step_k    = lapd_pkg::K_TENTH;
    priority if (mean_r < regs.thr_full) begin
      step_full = 1'b1;
    end else if (mean_r < regs.thr_eighty) begin
      step_k = lapd_pkg::K_EIGHTY;
    end else if (mean_r < regs.thr_half) begin
      step_k = lapd_pkg::K_HALF;
    end else if (mean_r < regs.thr_thirty) begin
      step_k = lapd_pkg::K_THIRTY;
    end else if (mean_r < regs.thr_tenth) begin
      step_k = lapd_pkg::K_TENTH;
    end else begin
      step_zero = 1'b1;
    end
  end

  // small constant multiple of the top value, exact before the divide by ten
  assign top_scaled = lapd_pkg::PROD_W'(regs.duty_top) * lapd_pkg::PROD_W'(step_k);

  // divide by ten as a multiply by the rounded-up reciprocal
  assign duty_prod = (2*lapd_pkg::PROD_W)'(scaled_r)
                   * (2*lapd_pkg::PROD_W)'(lapd_pkg::RECIP_TENTH);

  // output register frees as soon as its transaction completes
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt      = state_r;
    write_slot_nxt = write_slot_r;
    fill_count_nxt = fill_count_r;
    idx_nxt        = idx_r;
    sum_nxt        = sum_r;
    mean_nxt       = mean_r;
    duty_nxt       = duty_r;
    scaled_nxt     = scaled_r;
    div_req        = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          write_slot_nxt = (write_slot_r == lapd_pkg::IDX_W'(lapd_pkg::WINDOW - 1))
                           ? '0 : write_slot_r + lapd_pkg::IDX_W'(1);
          if (fill_count_r < lapd_pkg::CNT_W'(lapd_pkg::WINDOW)) begin
            fill_count_nxt = fill_count_r + lapd_pkg::CNT_W'(1);
          end
          idx_nxt   = '0;
          sum_nxt   = '0;
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        sum_nxt = sum_acc;
        idx_nxt = idx_r + lapd_pkg::IDX_W'(1);
        if (last_entry) begin
          // mean = sum / samples held
          div_req.start    = 1'b1;
          div_req.dividend = lapd_pkg::DIV_W'(sum_acc);
          div_req.divisor  = lapd_pkg::DVSR_W'(fill_count_r);
          state_nxt        = ST_DIV_MEAN;
        end
      end
      ST_DIV_MEAN: begin
        if (div_rsp.done) begin
          mean_nxt  = div_rsp.quotient[lapd_pkg::SAMPLE_W-1:0];
          state_nxt = ST_MAP;
        end
      end
      ST_MAP: begin
        if (step_full) begin
          duty_nxt  = regs.duty_top;
          state_nxt = ST_OUT;
        end else if (step_zero) begin
          duty_nxt  = '0;
          state_nxt = ST_OUT;
        end else begin
          // floor(top * k / 10) in the next cycle
          scaled_nxt = top_scaled;
          state_nxt  = ST_DIV_DUTY;
        end
      end
      ST_DIV_DUTY: begin
        duty_nxt  = duty_prod[lapd_pkg::RECIP_SHIFT +: lapd_pkg::TOP_W];
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_mean_nxt  = out_mean_r;
    out_duty_nxt  = out_duty_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_mean_nxt  = mean_r;
      out_duty_nxt  = duty_r;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      write_slot_r <= '0;
      fill_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      write_slot_r <= write_slot_nxt;
      fill_count_r <= fill_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    sum_r      <= sum_nxt;
    mean_r     <= mean_nxt;
    duty_r     <= duty_nxt;
    scaled_r   <= scaled_nxt;
    out_mean_r <= out_mean_nxt;
    out_duty_r <= out_duty_nxt;
    if (in_take) begin
      ring_r[write_slot_r] <= in_light_sample;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mean_level = out_mean_r;
  assign out_duty_value = out_duty_r;

endmodule
